FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the lexer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ptl_pkg.sv
// ----------------------------------------------------------------------------
// ptl_pkg
// shared types and constants of the prolog token lexer
// ----------------------------------------------------------------------------
package ptl_pkg;

    localparam int TEXT_CAPACITY_DEF = 32;
    localparam int IN_DATA_W         = 8;
    localparam int OUT_DATA_W        = 56;
    localparam int KIND_W            = 4;

    // token kinds
    localparam logic [3:0] K_EOF      = 4'd0;
    localparam logic [3:0] K_INT      = 4'd1;
    localparam logic [3:0] K_VAR      = 4'd2;
    localparam logic [3:0] K_ATOM     = 4'd3;
    localparam logic [3:0] K_STRING   = 4'd4;
    localparam logic [3:0] K_LPAREN   = 4'd5;
    localparam logic [3:0] K_RPAREN   = 4'd6;
    localparam logic [3:0] K_LBRACKET = 4'd7;
    localparam logic [3:0] K_RBRACKET = 4'd8;
    localparam logic [3:0] K_COMMA    = 4'd9;
    localparam logic [3:0] K_BAR      = 4'd10;
    localparam logic [3:0] K_DOT      = 4'd11;

    // byte constants
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_MINUS  = 8'h2d;

    // source of a stored text byte
    typedef enum logic [2:0] {
        KS_CHAR,
        KS_ESC,
        KS_SLASH,
        KS_DOT,
        KS_MINUS,
        KS_QUOTE
    } keep_sel_t;

    typedef struct packed {
        logic       in_load;
        logic       cnt_clear;
        logic       keep;
        keep_sel_t  keep_sel;
        logic       int_start;
        logic       int_neg;
        logic       acc_mac;
        logic       star_load;
        logic       star_val;
        logic       emit_start;
        logic [3:0] kind;
        logic       emit_int;
        logic       idx_inc;
        logic       hold_load;
        logic       hold_push;
        logic       push_last;
    } cmd_t;

    typedef struct packed {
        logic eoi;
        logic space;
        logic digit;
        logic upper;
        logic lower;
        logic under;
        logic name;
        logic symbol;
        logic pct;
        logic slash;
        logic star;
        logic squote;
        logic dquote;
        logic lparen;
        logic rparen;
        logic lbrack;
        logic rbrack;
        logic comma;
        logic bar;
        logic bang_semi;
        logic dot;
        logic minus;
        logic newline;
        logic backslash;
        logic room;
        logic star_seen;
        logic hold_valid;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

FILE: rtl/core/ptl_ram.sv
// ----------------------------------------------------------------------------
// ptl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ptl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/ptl_datapath.sv
// ----------------------------------------------------------------------------
// ptl_datapath
// byte classes, text store, number accumulator and result registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptl_datapath #(
    parameter int CAP = ptl_pkg::TEXT_CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ptl_pkg::cmd_t                  cmd,
    output ptl_pkg::sts_t                  sts,
    input  logic [ptl_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ptl_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [ptl_pkg::KIND_W-1:0]     m_tuser,
    output logic                           m_tlast
);

    localparam int CW = $clog2(CAP);

    logic [7:0]    char_reg;
    logic          eoi_reg;
    logic [CW-1:0] count_reg, count_next, count_base;
    logic [31:0]   acc_reg, acc_next;
    logic          neg_reg, neg_next;
    logic          star_reg;
    logic [CW-1:0] len_reg, idx_reg;
    logic [3:0]    tok_kind_reg;
    logic [31:0]   tok_value_reg;
    logic          room_base, wr_en;
    logic [7:0]    keep_byte, rd_data, res_byte;
    logic [CW-1:0] emit_cnt;

    logic          hold_valid_reg;
    logic [3:0]    hold_kind_reg;
    logic [31:0]   hold_value_reg;
    logic [7:0]    hold_byte_reg;
    logic [4:0]    hold_pos_reg, hold_len_reg;
    logic          hold_done_reg;

    logic          out_valid_reg;
    logic [3:0]    out_kind_reg;
    logic [50:0]   out_data_reg;
    logic          out_last_reg;

    // byte classes and status flags
    always_comb
    begin
        sts            = '0;
        sts.eoi        = eoi_reg;
        sts.space      = (char_reg == 8'd32) || (char_reg >= 8'd9 && char_reg <= 8'd13);
        sts.digit      = char_reg >= "0" && char_reg <= "9";
        sts.upper      = char_reg >= "A" && char_reg <= "Z";
        sts.lower      = char_reg >= "a" && char_reg <= "z";
        sts.under      = char_reg == "_";
        sts.name       = sts.digit || sts.upper || sts.lower || sts.under;
        sts.symbol     = char_reg == "+" || char_reg == "-" || char_reg == "*" ||
                         char_reg == "/" || char_reg == "\\" || char_reg == "<" ||
                         char_reg == ">" || char_reg == "=" || char_reg == ":" ||
                         char_reg == "?" || char_reg == "@" || char_reg == "#" ||
                         char_reg == "." || char_reg == "&" || char_reg == "^";
        sts.pct        = char_reg == ptl_pkg::CH_PCT;
        sts.slash      = char_reg == ptl_pkg::CH_SLASH;
        sts.star       = char_reg == ptl_pkg::CH_STAR;
        sts.squote     = char_reg == ptl_pkg::CH_SQUOTE;
        sts.dquote     = char_reg == ptl_pkg::CH_DQUOTE;
        sts.lparen     = char_reg == "(";
        sts.rparen     = char_reg == ")";
        sts.lbrack     = char_reg == "[";
        sts.rbrack     = char_reg == "]";
        sts.comma      = char_reg == ",";
        sts.bar        = char_reg == "|";
        sts.bang_semi  = char_reg == "!" || char_reg == ";";
        sts.dot        = char_reg == ptl_pkg::CH_DOT;
        sts.minus      = char_reg == ptl_pkg::CH_MINUS;
        sts.newline    = char_reg == ptl_pkg::CH_NL;
        sts.backslash  = char_reg == "\\";
        sts.room       = count_reg < CW'(CAP - 1);
        sts.star_seen  = star_reg;
        sts.hold_valid = hold_valid_reg;
        sts.out_free   = !out_valid_reg || m_tready;
        sts.emit_last  = (CW + 1)'(idx_reg) + (CW + 1)'(1) == (CW + 1)'(emit_cnt);
    end

    // text byte to store
    always_comb
    begin
        case (cmd.keep_sel)
            ptl_pkg::KS_CHAR:  keep_byte = char_reg;
            ptl_pkg::KS_ESC:   keep_byte = (char_reg == "n") ? ptl_pkg::CH_NL :
                                           (char_reg == "t") ? ptl_pkg::CH_TAB : char_reg;
            ptl_pkg::KS_SLASH: keep_byte = ptl_pkg::CH_SLASH;
            ptl_pkg::KS_DOT:   keep_byte = ptl_pkg::CH_DOT;
            ptl_pkg::KS_MINUS: keep_byte = ptl_pkg::CH_MINUS;
            ptl_pkg::KS_QUOTE: keep_byte = ptl_pkg::CH_SQUOTE;
            default:           keep_byte = char_reg;
        endcase
    end

    assign count_base = cmd.cnt_clear ? '0 : count_reg;
    assign room_base  = count_base < CW'(CAP - 1);
    assign wr_en      = cmd.keep && room_base;

    always_comb
    begin
        count_next = wr_en ? count_base + CW'(1) : count_base;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        if (cmd.int_start)
        begin
            acc_next = '0;
            neg_next = cmd.int_neg;
        end
        else if (cmd.acc_mac)
        begin
            acc_next = (acc_reg << 3) + (acc_reg << 1) + {24'd0, char_reg - ptl_pkg::CH_ZERO};
        end
        else if (cmd.emit_start && cmd.emit_int)
        begin
            acc_next = '0;
            neg_next = 1'b0;
        end
    end

    ptl_ram #(
        .WIDTH (8),
        .DEPTH (CAP)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_base),
        .wr_data (keep_byte),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign emit_cnt = (len_reg == '0) ? CW'(1) : len_reg;
    assign res_byte = (idx_reg < len_reg) ? rd_data : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            star_reg       <= 1'b0;
            len_reg        <= '0;
            idx_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= cmd.emit_start ? '0 : count_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            if (cmd.star_load)
            begin
                star_reg <= cmd.star_val;
            end
            if (cmd.emit_start)
            begin
                len_reg <= count_next;
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.hold_load)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.hold_push)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (cmd.hold_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            char_reg <= s_tdata;
            eoi_reg  <= s_tuser;
        end
        if (cmd.emit_start)
        begin
            tok_kind_reg  <= cmd.kind;
            tok_value_reg <= !cmd.emit_int ? 32'd0 : (neg_reg ? 32'd0 - acc_reg : acc_reg);
        end
        if (cmd.hold_push)
        begin
            out_kind_reg <= hold_kind_reg;
            out_data_reg <= {hold_done_reg, hold_len_reg, hold_pos_reg, hold_byte_reg,
                             hold_value_reg};
            out_last_reg <= cmd.push_last;
        end
        if (cmd.hold_load)
        begin
            hold_kind_reg  <= tok_kind_reg;
            hold_value_reg <= tok_value_reg;
            hold_byte_reg  <= res_byte;
            hold_pos_reg   <= 5'(idx_reg);
            hold_len_reg   <= 5'(len_reg);
            hold_done_reg  <= sts.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, (CW + 1)'(count_reg) < (CW + 1)'(CAP), "count overflow")
    `ASSERT_ALWAYS(a_idx_range, clk, rst_n, idx_reg <= emit_cnt, "emit index past token")
    `ASSERT_NEXT(a_push_shows, clk, rst_n, cmd.hold_push, m_tvalid, "pushed result not shown")

endmodule

FILE: rtl/core/ptl_controller.sv
// ----------------------------------------------------------------------------
// ptl_controller
// lexer phase machine and request sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptl_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ptl_pkg::sts_t sts,
    output ptl_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_WAIT   = 5'b00001,
        ST_STEP   = 5'b00010,
        ST_EADDR  = 5'b00100,
        ST_EPUT   = 5'b01000,
        ST_FINISH = 5'b10000
    } seq_t;

    typedef enum logic [13:0] {
        PH_IDLE       = 14'b00000000000001,
        PH_LINE       = 14'b00000000000010,
        PH_SLASH      = 14'b00000000000100,
        PH_BLOCK      = 14'b00000000001000,
        PH_INT        = 14'b00000000010000,
        PH_VAR        = 14'b00000000100000,
        PH_NAME       = 14'b00000001000000,
        PH_QUOTED     = 14'b00000010000000,
        PH_QUOTE_SEEN = 14'b00000100000000,
        PH_STRING     = 14'b00001000000000,
        PH_STRING_ESC = 14'b00010000000000,
        PH_DOT        = 14'b00100000000000,
        PH_MINUS      = 14'b01000000000000,
        PH_OP         = 14'b10000000000000
    } phase_t;

    seq_t          state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic          resume_reg, resume_next;
    logic          cont, emit;
    ptl_pkg::cmd_t pcmd;

    // one step of the phase machine on the held byte
    always_comb
    begin
        pcmd       = '0;
        pcmd.keep_sel = ptl_pkg::KS_CHAR;
        phase_next = phase_reg;
        cont       = 1'b0;
        emit       = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (sts.eoi)
                begin
                    emit = 1'b1;
                    pcmd.kind = ptl_pkg::K_EOF;
                end
                else
                begin
                    pcmd.cnt_clear = 1'b1;
                    if (sts.pct) phase_next = PH_LINE;
                    else if (sts.slash) phase_next = PH_SLASH;
                    else if (sts.space) phase_next = PH_IDLE;
                    else if (sts.digit)
                    begin
                        pcmd.int_start = 1'b1;
                        phase_next = PH_INT;
                        cont = 1'b1;
                    end
                    else if (sts.upper || sts.under)
                    begin
                        pcmd.keep = 1'b1;
                        phase_next = PH_VAR;
                    end
                    else if (sts.lower)
                    begin
                        pcmd.keep = 1'b1;
                        phase_next = PH_NAME;
                    end
                    else if (sts.squote) phase_next = PH_QUOTED;
                    else if (sts.dquote) phase_next = PH_STRING;
                    else if (sts.lparen)
                    begin
                        emit = 1'b1;
                        pcmd.kind = ptl_pkg::K_LPAREN;
                    end
                    else if (sts.rparen)
                    begin
                        emit = 1'b1;
                        pcmd.kind = ptl_pkg::K_RPAREN;
                    end
                    else if (sts.lbrack)
                    begin
                        emit = 1'b1;
                        pcmd.kind = ptl_pkg::K_LBRACKET;
                    end
                    else if (sts.rbrack)
                    begin
                        emit = 1'b1;
                        pcmd.kind = ptl_pkg::K_RBRACKET;
                    end
                    else if (sts.comma)
                    begin
                        emit = 1'b1;
                        pcmd.kind = ptl_pkg::K_COMMA;
                    end
                    else if (sts.bar)
                    begin
                        emit = 1'b1;
                        pcmd.kind = ptl_pkg::K_BAR;
                    end
                    else if (sts.bang_semi)
                    begin
                        pcmd.keep = 1'b1;
                        emit = 1'b1;
                        pcmd.kind = ptl_pkg::K_ATOM;
                    end
                    else if (sts.dot) phase_next = PH_DOT;
                    else if (sts.minus) phase_next = PH_MINUS;
                    else if (sts.symbol)
                    begin
                        pcmd.keep = 1'b1;
                        phase_next = PH_OP;
                    end
                end
            end
            PH_LINE:
            begin
                if (sts.eoi)
                begin
                    phase_next = PH_IDLE;
                    cont = 1'b1;
                end
                else if (sts.newline) phase_next = PH_IDLE;
            end
            PH_SLASH:
            begin
                if (!sts.eoi && sts.star)
                begin
                    phase_next = PH_BLOCK;
                    pcmd.star_load = 1'b1;
                end
                else
                begin
                    pcmd.cnt_clear = 1'b1;
                    pcmd.keep = 1'b1;
                    pcmd.keep_sel = ptl_pkg::KS_SLASH;
                    phase_next = PH_OP;
                    cont = 1'b1;
                end
            end
            PH_BLOCK:
            begin
                if (sts.eoi)
                begin
                    phase_next = PH_IDLE;
                    cont = 1'b1;
                end
                else if (sts.star_seen && sts.slash)
                begin
                    phase_next = PH_IDLE;
                    pcmd.star_load = 1'b1;
                end
                else
                begin
                    pcmd.star_load = 1'b1;
                    pcmd.star_val = sts.star;
                end
            end
            PH_INT:
            begin
                if (!sts.eoi && sts.digit && sts.room)
                begin
                    pcmd.keep = 1'b1;
                    pcmd.acc_mac = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                    pcmd.kind = ptl_pkg::K_INT;
                    pcmd.emit_int = 1'b1;
                    phase_next = PH_IDLE;
                    cont = 1'b1;
                end
            end
            PH_VAR, PH_NAME:
            begin
                if (!sts.eoi && sts.name && sts.room) pcmd.keep = 1'b1;
                else
                begin
                    emit = 1'b1;
                    pcmd.kind = (phase_reg == PH_VAR) ? ptl_pkg::K_VAR : ptl_pkg::K_ATOM;
                    phase_next = PH_IDLE;
                    cont = 1'b1;
                end
            end
            PH_OP:
            begin
                if (!sts.eoi && sts.symbol && sts.room) pcmd.keep = 1'b1;
                else
                begin
                    emit = 1'b1;
                    pcmd.kind = ptl_pkg::K_ATOM;
                    phase_next = PH_IDLE;
                    cont = 1'b1;
                end
            end
            PH_QUOTED:
            begin
                if (sts.eoi || sts.newline)
                begin
                    emit = 1'b1;
                    pcmd.kind = ptl_pkg::K_ATOM;
                    phase_next = PH_IDLE;
                    cont = sts.eoi;
                end
                else if (sts.squote) phase_next = PH_QUOTE_SEEN;
                else pcmd.keep = 1'b1;
            end
            PH_QUOTE_SEEN:
            begin
                if (!sts.eoi && sts.squote)
                begin
                    pcmd.keep = 1'b1;
                    pcmd.keep_sel = ptl_pkg::KS_QUOTE;
                    phase_next = PH_QUOTED;
                end
                else
                begin
                    emit = 1'b1;
                    pcmd.kind = ptl_pkg::K_ATOM;
                    phase_next = PH_IDLE;
                    cont = 1'b1;
                end
            end
            PH_STRING:
            begin
                if (sts.eoi || sts.dquote)
                begin
                    emit = 1'b1;
                    pcmd.kind = ptl_pkg::K_STRING;
                    phase_next = PH_IDLE;
                    cont = sts.eoi;
                end
                else if (sts.backslash) phase_next = PH_STRING_ESC;
                else pcmd.keep = 1'b1;
            end
            PH_STRING_ESC:
            begin
                if (sts.eoi)
                begin
                    emit = 1'b1;
                    pcmd.kind = ptl_pkg::K_STRING;
                    phase_next = PH_IDLE;
                    cont = 1'b1;
                end
                else
                begin
                    pcmd.keep = 1'b1;
                    pcmd.keep_sel = ptl_pkg::KS_ESC;
                    phase_next = PH_STRING;
                end
            end
            PH_DOT:
            begin
                if (sts.eoi || sts.space)
                begin
                    emit = 1'b1;
                    pcmd.kind = ptl_pkg::K_DOT;
                    phase_next = PH_IDLE;
                    cont = 1'b1;
                end
                else
                begin
                    pcmd.cnt_clear = 1'b1;
                    pcmd.keep = 1'b1;
                    pcmd.keep_sel = ptl_pkg::KS_DOT;
                    phase_next = PH_OP;
                    cont = 1'b1;
                end
            end
            PH_MINUS:
            begin
                if (!sts.eoi && sts.digit)
                begin
                    pcmd.int_start = 1'b1;
                    pcmd.int_neg = 1'b1;
                    pcmd.cnt_clear = 1'b1;
                    phase_next = PH_INT;
                end
                else
                begin
                    pcmd.cnt_clear = 1'b1;
                    pcmd.keep = 1'b1;
                    pcmd.keep_sel = ptl_pkg::KS_MINUS;
                    phase_next = PH_OP;
                end
                cont = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
                pcmd.cnt_clear = 1'b1;
                cont = 1'b1;
            end
        endcase
        if (pcmd.int_start)
        begin
            pcmd.cnt_clear = 1'b1;
        end
        pcmd.emit_start = emit;
    end

    // request sequencer
    always_comb
    begin
        cmd         = '0;
        cmd.keep_sel = ptl_pkg::KS_CHAR;
        state_next  = state_reg;
        resume_next = resume_reg;
        in_ready    = 1'b0;
        case (state_reg)
            ST_WAIT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd = pcmd;
                if (emit)
                begin
                    state_next  = ST_EADDR;
                    resume_next = cont;
                end
                else if (!cont)
                begin
                    state_next = sts.hold_valid ? ST_FINISH : ST_WAIT;
                end
            end
            ST_EADDR:
            begin
                state_next = ST_EPUT;
            end
            ST_EPUT:
            begin
                if (!sts.hold_valid || sts.out_free)
                begin
                    cmd.hold_push = sts.hold_valid;
                    cmd.hold_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    if (sts.emit_last) state_next = resume_reg ? ST_STEP : ST_FINISH;
                    else state_next = ST_EADDR;
                end
            end
            ST_FINISH:
            begin
                if (!sts.hold_valid) state_next = ST_WAIT;
                else if (sts.out_free)
                begin
                    cmd.hold_push = 1'b1;
                    cmd.push_last = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_WAIT;
            phase_reg  <= PH_IDLE;
            resume_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            if (state_reg == ST_STEP)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    `ASSERT_IMPLY(a_wait_drained, clk, rst_n, state_reg == ST_WAIT, !sts.hold_valid, "result left in hold")
    `ASSERT_IMPLY(a_push_room, clk, rst_n, cmd.hold_push, sts.out_free, "push into busy output")
    `ASSERT_NEXT(a_accept_step, clk, rst_n, in_valid && in_ready, state_reg == ST_STEP, "accept without step")

endmodule

FILE: rtl/core/prolog_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// prolog_token_lexer_unit
// streaming tokenizer for prolog source, one byte per request
// ----------------------------------------------------------------------------
// usage:
//   s_* carries source bytes in s_tdata, s_tuser high marks end of input
//   m_* carries results: one request per stored token text byte, or one
//   request for a token without text; m_tlast marks the final result caused
//   by one input request, token_done in m_tdata the final one of a token
//   an input request is taken only when the previous one has been fully
//   processed; a byte that finishes no token passes an accept and a step
//   state, a re-classified byte takes an extra phase step, and each result
//   passes a text ram read, then a load of the hold register, with a
//   final state to release the last result of the request
//   results pass a hold register and an output register, so a stalled
//   receiver only blocks the block when both are full
//   reset clears the phase to idle and empties both result registers;
//   the text store needs no clearing since only written bytes are read
// ----------------------------------------------------------------------------
module prolog_token_lexer_unit #(
    parameter int TEXT_CAPACITY = ptl_pkg::TEXT_CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ptl_pkg::IN_DATA_W-1:0]  s_tdata,   // char_code[7:0]
    input  logic                           s_tuser,   // end_of_input
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // int_value[31:0], text_byte[39:32], text_position[44:40],
    // text_length[49:45], token_done[50], zero fill
    output logic [ptl_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [ptl_pkg::KIND_W-1:0]     m_tuser,   // token_kind
    output logic                           m_tlast    // last
);

    ptl_pkg::cmd_t cmd;
    ptl_pkg::sts_t sts;

    // phase machine and sequencing of steps and result requests
    ptl_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // byte classes, text ram, accumulator, hold and output registers
    ptl_datapath #(
        .CAP (TEXT_CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the prolog token lexer against a cycle-free token predictor:
// directed source snippets for every token kind and corner case, then
// random well-formed token streams mixed with noise, with random gaps and
// stalls on both streams and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ptl_pkg::*;

    localparam int CAP = TEXT_CAPACITY_DEF;

    // lexer phases of the predictor
    typedef enum int {
        PH_IDLE, PH_LINE, PH_SLASH, PH_BLOCK, PH_INT, PH_VAR, PH_NAME,
        PH_QUOTED, PH_QUOTE_SEEN, PH_STRING, PH_STRING_ESC, PH_DOT,
        PH_MINUS, PH_OP
    } phase_t;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [7:0]  tbyte;
        logic [4:0]  pos;
        logic [4:0]  len;
        logic        done;
        logic        last;
    } token_beat_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic m_tlast;

    prolog_token_lexer_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // predictor state
    phase_t      lex_phase;
    logic [7:0]  lex_text [CAP];
    int          lex_count;
    logic [31:0] lex_acc;
    logic        lex_neg;
    logic        lex_star;

    token_beat_t expected_beats[$];
    int          step_beats;
    int          errors;
    int          requests_taken;
    int          items_sent;
    bit          no_idle;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic bit is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_upper(logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic bit is_lower(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit is_name(logic [7:0] c);
        return is_digit(c) || is_upper(c) || is_lower(c) || c == "_";
    endfunction

    function automatic bit is_symbol(logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "\\" ||
               c == "<" || c == ">" || c == "=" || c == ":" || c == "?" ||
               c == "@" || c == "#" || c == "." || c == "&" || c == "^";
    endfunction

    function automatic bit has_room();
        return lex_count < CAP - 1;
    endfunction

    function automatic void keep_byte(logic [7:0] c);
        if (has_room())
        begin
            lex_text[lex_count] = c;
            lex_count++;
        end
    endfunction

    // queue one result per stored text byte, or one for an empty token
    function automatic void emit_token(logic [3:0] kind, logic [31:0] value);
        token_beat_t b;
        int n;
        n = (lex_count > 0) ? lex_count : 1;
        for (int i = 0; i < n; i++)
        begin
            b.kind  = kind;
            b.value = value;
            b.tbyte = (i < lex_count) ? lex_text[i] : 8'd0;
            b.pos   = i[4:0];
            b.len   = lex_count[4:0];
            b.done  = (i == n - 1);
            b.last  = 1'b0;
            expected_beats.push_back(b);
            step_beats++;
        end
        lex_count = 0;
    endfunction

    function automatic void start_int(logic neg);
        lex_phase = PH_INT;
        lex_acc   = '0;
        lex_neg   = neg;
        lex_count = 0;
    endfunction

    // one source byte through the lexer; a byte that ends a token is
    // classified again in the following phase
    function automatic void lex_step(logic [7:0] ch, logic eoi);
        logic [7:0] c;
        bit again;
        c = ch;
        step_beats = 0;
        do
        begin
            again = 0;
            case (lex_phase)
                PH_IDLE:
                begin
                    if (eoi)
                        emit_token(K_EOF, 0);
                    else
                    begin
                        lex_count = 0;
                        if (c == CH_PCT) lex_phase = PH_LINE;
                        else if (c == CH_SLASH) lex_phase = PH_SLASH;
                        else if (is_space(c)) ;
                        else if (is_digit(c)) begin start_int(0); again = 1; end
                        else if (is_upper(c) || c == "_") begin lex_phase = PH_VAR; keep_byte(c); end
                        else if (is_lower(c)) begin lex_phase = PH_NAME; keep_byte(c); end
                        else if (c == CH_SQUOTE) lex_phase = PH_QUOTED;
                        else if (c == CH_DQUOTE) lex_phase = PH_STRING;
                        else if (c == "(") emit_token(K_LPAREN, 0);
                        else if (c == ")") emit_token(K_RPAREN, 0);
                        else if (c == "[") emit_token(K_LBRACKET, 0);
                        else if (c == "]") emit_token(K_RBRACKET, 0);
                        else if (c == ",") emit_token(K_COMMA, 0);
                        else if (c == "|") emit_token(K_BAR, 0);
                        else if (c == "!" || c == ";") begin keep_byte(c); emit_token(K_ATOM, 0); end
                        else if (c == CH_DOT) lex_phase = PH_DOT;
                        else if (c == CH_MINUS) lex_phase = PH_MINUS;
                        else if (is_symbol(c)) begin lex_phase = PH_OP; keep_byte(c); end
                    end
                end
                PH_LINE:
                begin
                    if (eoi) begin lex_phase = PH_IDLE; again = 1; end
                    else if (c == CH_NL) lex_phase = PH_IDLE;
                end
                PH_SLASH:
                begin
                    if (!eoi && c == CH_STAR)
                    begin
                        lex_phase = PH_BLOCK;
                        lex_star  = 0;
                    end
                    else
                    begin
                        lex_count = 0;
                        keep_byte(CH_SLASH);
                        lex_phase = PH_OP;
                        again = 1;
                    end
                end
                PH_BLOCK:
                begin
                    if (eoi) begin lex_phase = PH_IDLE; again = 1; end
                    else if (lex_star && c == CH_SLASH) begin lex_phase = PH_IDLE; lex_star = 0; end
                    else lex_star = (c == CH_STAR);
                end
                PH_INT:
                begin
                    if (!eoi && is_digit(c) && has_room())
                    begin
                        keep_byte(c);
                        lex_acc = lex_acc * 10 + 32'(c - CH_ZERO);
                    end
                    else
                    begin
                        emit_token(K_INT, lex_neg ? -lex_acc : lex_acc);
                        lex_acc   = '0;
                        lex_neg   = 0;
                        lex_phase = PH_IDLE;
                        again = 1;
                    end
                end
                PH_VAR, PH_NAME:
                begin
                    if (!eoi && is_name(c) && has_room())
                        keep_byte(c);
                    else
                    begin
                        emit_token(lex_phase == PH_VAR ? K_VAR : K_ATOM, 0);
                        lex_phase = PH_IDLE;
                        again = 1;
                    end
                end
                PH_OP:
                begin
                    if (!eoi && is_symbol(c) && has_room())
                        keep_byte(c);
                    else
                    begin
                        emit_token(K_ATOM, 0);
                        lex_phase = PH_IDLE;
                        again = 1;
                    end
                end
                PH_QUOTED:
                begin
                    if (eoi || c == CH_NL)
                    begin
                        emit_token(K_ATOM, 0);
                        lex_phase = PH_IDLE;
                        again = eoi;
                    end
                    else if (c == CH_SQUOTE) lex_phase = PH_QUOTE_SEEN;
                    else keep_byte(c);
                end
                PH_QUOTE_SEEN:
                begin
                    if (!eoi && c == CH_SQUOTE)
                    begin
                        keep_byte(CH_SQUOTE);
                        lex_phase = PH_QUOTED;
                    end
                    else
                    begin
                        emit_token(K_ATOM, 0);
                        lex_phase = PH_IDLE;
                        again = 1;
                    end
                end
                PH_STRING:
                begin
                    if (eoi || c == CH_DQUOTE)
                    begin
                        emit_token(K_STRING, 0);
                        lex_phase = PH_IDLE;
                        again = eoi;
                    end
                    else if (c == "\\") lex_phase = PH_STRING_ESC;
                    else keep_byte(c);
                end
                PH_STRING_ESC:
                begin
                    if (eoi)
                    begin
                        emit_token(K_STRING, 0);
                        lex_phase = PH_IDLE;
                        again = 1;
                    end
                    else
                    begin
                        if (c == "n") c = CH_NL;
                        else if (c == "t") c = CH_TAB;
                        keep_byte(c);
                        lex_phase = PH_STRING;
                    end
                end
                PH_DOT:
                begin
                    if (eoi || is_space(c))
                        emit_token(K_DOT, 0);
                    else
                    begin
                        lex_count = 0;
                        keep_byte(CH_DOT);
                    end
                    lex_phase = (eoi || is_space(c)) ? PH_IDLE : PH_OP;
                    again = 1;
                end
                PH_MINUS:
                begin
                    if (!eoi && is_digit(c))
                        start_int(1);
                    else
                    begin
                        lex_count = 0;
                        keep_byte(CH_MINUS);
                        lex_phase = PH_OP;
                    end
                    again = 1;
                end
                default:
                begin
                    lex_phase = PH_IDLE;
                    lex_count = 0;
                    again = 1;
                end
            endcase
        end
        while (again);
        if (step_beats > 0)
            expected_beats[expected_beats.size() - 1].last = 1'b1;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %0h got %0h at %0t", field, want, got, $realtime);
        errors++;
    endtask

    // request on the input side feeds the predictor before results are checked
    always @(posedge clk)
    begin
        token_beat_t e;
        if (rst_n && s_tvalid && s_tready)
        begin
            lex_step(s_tdata, s_tuser);
            requests_taken <= requests_taken + 1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected result", 0, m_tdata[31:0]);
            else
            begin
                e = expected_beats.pop_front();
                if (m_tuser !== e.kind) report_mismatch("token_kind", e.kind, m_tuser);
                if (m_tdata[31:0] !== e.value) report_mismatch("int_value", e.value, m_tdata[31:0]);
                if (m_tdata[39:32] !== e.tbyte) report_mismatch("text_byte", e.tbyte, m_tdata[39:32]);
                if (m_tdata[44:40] !== e.pos) report_mismatch("text_position", e.pos, m_tdata[44:40]);
                if (m_tdata[49:45] !== e.len) report_mismatch("text_length", e.len, m_tdata[49:45]);
                if (m_tdata[50] !== e.done) report_mismatch("token_done", e.done, m_tdata[50]);
                if (m_tlast !== e.last) report_mismatch("last", e.last, m_tlast);
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= no_idle || ($urandom_range(0, 99) >= 20);
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_item(logic [7:0] c, logic eoi);
        int taken;
        if (!no_idle && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eoi;
        taken = requests_taken;
        do @(negedge clk); while (requests_taken == taken);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_eoi();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_basic_tokens();
        send_text("f(X_1,[a|b]). ");
        send_text("!;- .+");
        send_eoi();
    endtask

    task automatic test_numbers();
        // largest unsigned value fits the accumulator, minus binds only to a digit
        send_text("0 4294967295 -12 ");
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_eoi();
    endtask

    task automatic test_comments_and_quotes();
        send_text("/**x*/ /+ %c\n'it''s'\n'ab\n");
        send_text("\"a\\nb\\t\\q\" ");
        send_text("\"z\\");
        send_eoi();
        send_text("/*");
        send_eoi();
    endtask

    task automatic test_long_tokens();
        // full text splits names and numbers, truncates quoted text
        send_text("abcdefghijklmnopqrstuvwxyz0123456789 ");
        send_text("'abcdefghijklmnopqrstuvwxyz0123456789' ");
        send_text("1234567890123456789012345678901234 ");
        send_text("+++++++++++++++++++++++++++++++++++ ");
    endtask

    function automatic string rand_from(string set, int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, set.substr($urandom_range(0, set.len() - 1), 0)};
        return s;
    endfunction

    // one random token, mostly well formed
    task automatic send_random_token();
        int n;
        string sign;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
        sign = "";
        if ($urandom_range(0, 1))
            sign = "-";
        case ($urandom_range(0, 11))
            0: send_text({sign, rand_from("0123456789", n)});
            1: send_text({rand_from("ABZ_", 1), rand_from("azAZ09_", n - 1)});
            2: send_text({rand_from("amz", 1), rand_from("azAZ09_", n - 1)});
            3: send_text({"'", rand_from("ab '\n", n), "'"});
            4: send_text({"\"", rand_from("xy\\nt", n), "\""});
            5: send_text(rand_from("()[],|!;", 1));
            6: send_text(rand_from("+-*/\\<>=:?@#.&^", n));
            7: send_text(". ");
            8: send_text({"% ", rand_from("ab*/", n), "\n"});
            9: send_text({"/*", rand_from("a*/", n), "*/"});
            10: send_item(8'($urandom_range(0, 255)), 1'b0);
            default: send_eoi();
        endcase
        if ($urandom_range(0, 1)) send_text(rand_from(" \t\n", 1));
    endtask

    task automatic test_random_stream();
        while (items_sent < 400)
        begin
            // stretch without any idling on either side
            no_idle = (items_sent >= 300 && items_sent < 370);
            send_random_token();
        end
        no_idle = 0;
        send_eoi();
    endtask

    task automatic test_receiver_holdoff();
        // receiver stalls long enough for the block to back up its input
        hold_cycles = 300;
        repeat (10) send_text("ab 12 ");
        send_eoi();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        errors   = 0;
        requests_taken = 0;
        items_sent = 0;
        no_idle  = 0;
        hold_cycles = 0;
        lex_phase = PH_IDLE;
        lex_count = 0;
        lex_acc   = '0;
        lex_neg   = 0;
        lex_star  = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_basic_tokens();
        test_numbers();
        test_comments_and_quotes();
        test_long_tokens();
        test_receiver_holdoff();
        test_random_stream();
        s_tvalid <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("[prolog_token_lexer_unit] OK");
        else
            $display("[prolog_token_lexer_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[prolog_token_lexer_unit] ERROR");
        $finish;
    end

endmodule
